FILE: sv/mtb_pkg.sv
// package for the metronome beat timer
// holds the sequencer and action codes, divider handshake structs and constants
// no dependencies

package mtb_pkg;

    // field and register widths
    localparam int unsigned BUTTON_W   = 5;
    localparam int unsigned HELD_W     = 3;
    localparam int unsigned TEMPO_W    = 9;
    localparam int unsigned TONE_W     = 8;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 9;
    localparam int unsigned STEP_CNT_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BPM_UPPER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BPM_LOWER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_LENGTH = 2'd2;

    // reset values
    localparam logic [TEMPO_W-1:0] BPM_UPPER_RESET   = 9'd300;
    localparam logic [TEMPO_W-1:0] BPM_LOWER_RESET   = 9'd1;
    localparam logic [TONE_W-1:0]  TONE_LENGTH_RESET = 8'd25;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET       = 9'd60;

    // one minute and one second in ticks
    localparam logic [INTERVAL_W-1:0] MINUTE_TICKS = 16'd60000;
    localparam logic [INTERVAL_W-1:0] SECOND_TICKS = 16'd1000;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET =
        SECOND_TICKS - INTERVAL_W'(TONE_LENGTH_RESET);

    // step sizes
    localparam logic [TEMPO_W-1:0] STEP_SMALL = 9'd1;
    localparam logic [TEMPO_W-1:0] STEP_LARGE = 9'd10;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    // button actions, coded as the held button number
    typedef enum logic [HELD_W-1:0] {
        ACT_NONE      = 3'd0,
        ACT_RESTART   = 3'd1,
        ACT_DIRECTION = 3'd2,
        ACT_STEP_ONE  = 3'd3,
        ACT_STEP_TEN  = 3'd4,
        ACT_MUTE      = 3'd5
    } t_action;

    // divider request and response
    typedef struct packed {
        logic               start;
        logic [TEMPO_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [INTERVAL_W-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: sv/mtb_div.sv
// bit-serial restoring divider: one minute of ticks divided by the tempo
// one quotient bit per cycle, done pulses with the finished quotient
// depends on mtb_pkg

module mtb_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtb_pkg::t_div_req i_req,
    output mtb_pkg::t_div_rsp o_rsp
);

    logic                                r_busy;
    logic                                n_busy;
    logic                                r_done;
    logic                                n_done;
    logic [mtb_pkg::STEP_CNT_W-1:0]      r_count;
    logic [mtb_pkg::STEP_CNT_W-1:0]      n_count;
    logic [mtb_pkg::TEMPO_W-1:0]         r_divisor;
    logic [mtb_pkg::TEMPO_W-1:0]         n_divisor;
    logic [mtb_pkg::TEMPO_W-1:0]         r_rem;
    logic [mtb_pkg::TEMPO_W-1:0]         n_rem;
    logic [mtb_pkg::INTERVAL_W-1:0]      r_quo;
    logic [mtb_pkg::INTERVAL_W-1:0]      n_quo;
    logic [mtb_pkg::TEMPO_W:0]           trial;
    logic [mtb_pkg::TEMPO_W:0]           diff;

    // shift-subtract step; a zero divisor yields all ones, the saturated quotient
    always_comb begin
        trial     = {r_rem, r_quo[mtb_pkg::INTERVAL_W-1]};
        diff      = trial - {1'b0, r_divisor};
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_count   = r_count;
        n_divisor = r_divisor;
        n_rem     = r_rem;
        n_quo     = r_quo;
        if (i_req.start) begin
            n_busy    = 1'b1;
            n_count   = '1;
            n_divisor = i_req.divisor;
            n_rem     = '0;
            n_quo     = mtb_pkg::MINUTE_TICKS;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_divisor}) begin
                n_rem = diff[mtb_pkg::TEMPO_W-1:0];
                n_quo = {r_quo[mtb_pkg::INTERVAL_W-2:0], 1'b1};
            end else begin
                n_rem = trial[mtb_pkg::TEMPO_W-1:0];
                n_quo = {r_quo[mtb_pkg::INTERVAL_W-2:0], 1'b0};
            end
            n_count = r_count - 1'b1;
            if (r_count == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_count   <= n_count;
        r_divisor <= n_divisor;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: sv/metronome_beat_timer.sv
// Metronome beat timer: one input item is one millisecond tick with five button
// levels, one result item per tick. A tick that releases a step button goes from
// the idle state to the divide state, where the beat interval is recomputed by a
// bit-serial divider that produces one quotient bit per cycle; the interval
// register takes the quotient as the sequencer moves to the finishing state, which
// loads the output register. Any other tick goes from idle straight to the
// finishing state. The next item is taken only when the sequencer is back in idle.
// While the previous result still waits unread in the output register, the
// loading of the new result, and the input ready, are held back. The input is
// ready whenever the sequencer is idle, also while the previous result still
// waits in the output register.
// Register writes apply at the next reset or step action.
// depends on mtb_pkg and mtb_div

module metronome_beat_timer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_wr_en,
    input  logic [mtb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mtb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input items
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [mtb_pkg::BUTTON_W-1:0]     i_button_levels,
    // result items
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_beep,
    output logic [mtb_pkg::TEMPO_W-1:0]      o_tempo,
    output logic                             o_counting_down,
    output logic                             o_silenced,
    output logic                             o_settings_changed,
    output logic [mtb_pkg::INTERVAL_W-1:0]   o_beat_interval
);

    mtb_pkg::t_state                    r_state;
    mtb_pkg::t_state                    n_state;

    logic [mtb_pkg::TEMPO_W-1:0]        r_bpm_upper;
    logic [mtb_pkg::TEMPO_W-1:0]        r_bpm_lower;
    logic [mtb_pkg::TONE_W-1:0]         r_tone_length;

    logic [mtb_pkg::HELD_W-1:0]         r_held;
    logic [mtb_pkg::HELD_W-1:0]         n_held;
    logic [mtb_pkg::TEMPO_W-1:0]        r_tempo;
    logic [mtb_pkg::TEMPO_W-1:0]        n_tempo;
    logic                               r_down;
    logic                               n_down;
    logic                               r_mute;
    logic                               n_mute;
    logic [mtb_pkg::INTERVAL_W-1:0]     r_interval;
    logic [mtb_pkg::INTERVAL_W-1:0]     n_interval;
    logic [mtb_pkg::INTERVAL_W-1:0]     r_tick;
    logic [mtb_pkg::INTERVAL_W-1:0]     n_tick;
    logic                               r_changed;
    logic                               n_changed;

    logic                               r_out_valid;
    logic                               n_out_valid;
    logic                               r_beep;
    logic                               n_beep;
    logic [mtb_pkg::TEMPO_W-1:0]        r_out_tempo;
    logic                               r_out_down;
    logic                               r_out_mute;
    logic                               r_out_changed;
    logic [mtb_pkg::INTERVAL_W-1:0]     r_out_interval;

    logic                               accept;
    logic                               finish_fire;
    logic                               blocked;
    logic                               release_fire;
    mtb_pkg::t_action                   action;
    logic                               is_step;
    logic [mtb_pkg::TEMPO_W-1:0]        step_amount;
    logic signed [mtb_pkg::TEMPO_W+1:0] step_sum;
    logic [mtb_pkg::TEMPO_W-1:0]        step_tempo;
    logic [mtb_pkg::INTERVAL_W-1:0]     tick_inc;

    mtb_pkg::t_div_req                  div_req;
    mtb_pkg::t_div_rsp                  div_rsp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpm_upper   <= mtb_pkg::BPM_UPPER_RESET;
            r_bpm_lower   <= mtb_pkg::BPM_LOWER_RESET;
            r_tone_length <= mtb_pkg::TONE_LENGTH_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mtb_pkg::REG_BPM_UPPER:   r_bpm_upper   <= i_cfg_data;
                mtb_pkg::REG_BPM_LOWER:   r_bpm_lower   <= i_cfg_data;
                mtb_pkg::REG_TONE_LENGTH: r_tone_length <= i_cfg_data[mtb_pkg::TONE_W-1:0];
                default: ;
            endcase
        end
    end

    // button scan: the held button acts on release unless a lower button is pressed
    always_comb begin
        blocked = 1'b0;
        n_held  = '0;
        for (int k = 0; k < mtb_pkg::BUTTON_W; k++) begin
            if (mtb_pkg::HELD_W'(k) < r_held) begin
                blocked = blocked | i_button_levels[k];
            end
            if (i_button_levels[k]) begin
                n_held = mtb_pkg::HELD_W'(k + 1);
            end
        end
        release_fire = 1'b0;
        action       = mtb_pkg::ACT_NONE;
        case (r_held)
            mtb_pkg::ACT_RESTART, mtb_pkg::ACT_DIRECTION, mtb_pkg::ACT_STEP_ONE,
            mtb_pkg::ACT_STEP_TEN, mtb_pkg::ACT_MUTE: begin
                release_fire = !blocked;
                action       = blocked ? mtb_pkg::ACT_NONE : mtb_pkg::t_action'(r_held);
            end
            default: ;
        endcase
    end

    // tempo step with saturation, upper bound checked first
    always_comb begin
        is_step     = (action == mtb_pkg::ACT_STEP_ONE) || (action == mtb_pkg::ACT_STEP_TEN);
        step_amount = (action == mtb_pkg::ACT_STEP_TEN) ? mtb_pkg::STEP_LARGE
                                                        : mtb_pkg::STEP_SMALL;
        if (r_down) begin
            step_sum = $signed({2'b00, r_tempo}) - $signed({2'b00, step_amount});
        end else begin
            step_sum = $signed({2'b00, r_tempo}) + $signed({2'b00, step_amount});
        end
        if (step_sum > $signed({2'b00, r_bpm_upper})) begin
            step_tempo = r_bpm_upper;
        end else if (step_sum < $signed({2'b00, r_bpm_lower})) begin
            step_tempo = r_bpm_lower;
        end else begin
            step_tempo = step_sum[mtb_pkg::TEMPO_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mtb_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = is_step ? mtb_pkg::ST_DIVIDE : mtb_pkg::ST_FINISH;
                end
            end
            mtb_pkg::ST_DIVIDE: begin
                if (div_rsp.done) begin
                    n_state = mtb_pkg::ST_FINISH;
                end
            end
            mtb_pkg::ST_FINISH: begin
                if (finish_fire) begin
                    n_state = mtb_pkg::ST_IDLE;
                end
            end
            default: n_state = mtb_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_ready     = (r_state == mtb_pkg::ST_IDLE);
        accept      = i_valid && o_ready;
        finish_fire = (r_state == mtb_pkg::ST_FINISH) && (!r_out_valid || i_ready);
        div_req.start   = accept && is_step;
        div_req.divisor = step_tempo;
    end

    // divider for the step actions
    mtb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // state updates: button action, interval, beat counter, output register
    always_comb begin
        n_tempo     = r_tempo;
        n_down      = r_down;
        n_mute      = r_mute;
        n_interval  = r_interval;
        n_tick      = r_tick;
        n_changed   = r_changed;
        n_out_valid = r_out_valid && !i_ready;
        n_beep      = 1'b0;
        tick_inc    = r_tick + 1'b1;
        if (accept) begin
            n_changed = release_fire;
            case (action)
                mtb_pkg::ACT_RESTART: begin
                    n_tempo    = mtb_pkg::TEMPO_RESET;
                    n_down     = 1'b0;
                    n_mute     = 1'b1;
                    n_interval = mtb_pkg::SECOND_TICKS
                               - mtb_pkg::INTERVAL_W'(r_tone_length);
                end
                mtb_pkg::ACT_DIRECTION: n_down = !r_down;
                mtb_pkg::ACT_STEP_ONE,
                mtb_pkg::ACT_STEP_TEN:  n_tempo = step_tempo;
                mtb_pkg::ACT_MUTE:      n_mute = !r_mute;
                default: ;
            endcase
        end
        // interval from the quotient, clamped at zero
        if ((r_state == mtb_pkg::ST_DIVIDE) && div_rsp.done) begin
            if (div_rsp.quotient > mtb_pkg::INTERVAL_W'(r_tone_length)) begin
                n_interval = div_rsp.quotient - mtb_pkg::INTERVAL_W'(r_tone_length);
            end else begin
                n_interval = '0;
            end
        end
        // beat counter advances after the action
        if (finish_fire) begin
            n_out_valid = 1'b1;
            if (!r_mute) begin
                if (tick_inc >= r_interval) begin
                    n_beep = 1'b1;
                    n_tick = '0;
                end else begin
                    n_tick = tick_inc;
                end
            end
        end
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtb_pkg::ST_IDLE;
            r_held      <= '0;
            r_tempo     <= mtb_pkg::TEMPO_RESET;
            r_down      <= 1'b0;
            r_mute      <= 1'b1;
            r_interval  <= mtb_pkg::INTERVAL_RESET;
            r_tick      <= '0;
            r_changed   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tempo     <= n_tempo;
            r_down      <= n_down;
            r_mute      <= n_mute;
            r_interval  <= n_interval;
            r_tick      <= n_tick;
            r_changed   <= n_changed;
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_held <= n_held;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (finish_fire) begin
            r_beep         <= n_beep;
            r_out_tempo    <= r_tempo;
            r_out_down     <= r_down;
            r_out_mute     <= r_mute;
            r_out_changed  <= r_changed;
            r_out_interval <= r_interval;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_beep             = r_beep;
    assign o_tempo            = r_out_tempo;
    assign o_counting_down    = r_out_down;
    assign o_silenced         = r_out_mute;
    assign o_settings_changed = r_out_changed;
    assign o_beat_interval    = r_out_interval;

    // a beat is never reported while muted
    a_beep_unmuted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_beep) |-> !o_silenced)
        else $error("beep reported while muted");

    // the divider finishing always hands over to the finishing step
    a_div_to_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == mtb_pkg::ST_DIVIDE) && div_rsp.done) |=> (r_state == mtb_pkg::ST_FINISH))
        else $error("divider result not taken");

    // an item without a step action skips the divider
    a_no_step_no_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_step) |=> (r_state == mtb_pkg::ST_FINISH))
        else $error("non-step item entered the divider");

endmodule

FILE: tb/metronome_beat_timer_tb.sv
// testbench for the metronome beat timer: directed button sequences, then random phases
// keeps its own tick-by-tick model of tempo, direction, mute and beat counting
// depends on mtb_pkg and the metronome_beat_timer rtl

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // index that no register answers to
    localparam logic [mtb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_COUNT = 9;
    localparam int PHASE_TICKS = 135;

    typedef struct packed {
        logic                           beep;
        logic [mtb_pkg::TEMPO_W-1:0]    tempo;
        logic                           counting_down;
        logic                           silenced;
        logic                           settings_changed;
        logic [mtb_pkg::INTERVAL_W-1:0] beat_interval;
    } t_tick_result;

    typedef struct {
        bit                             is_write;
        logic [mtb_pkg::CFG_IDX_W-1:0]  reg_index;
        logic [mtb_pkg::CFG_DATA_W-1:0] reg_data;
        logic [mtb_pkg::BUTTON_W-1:0]   levels;
        bit                             has_typed;
        t_tick_result                   typed;
    } t_directed_row;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_PERIODIC,
        RX_RANDOM
    } t_rx_mode;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_wr_en = 1'b0;
    logic [mtb_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [mtb_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic [mtb_pkg::BUTTON_W-1:0]   i_button_levels = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic                           o_beep;
    logic [mtb_pkg::TEMPO_W-1:0]    o_tempo;
    logic                           o_counting_down;
    logic                           o_silenced;
    logic                           o_settings_changed;
    logic [mtb_pkg::INTERVAL_W-1:0] o_beat_interval;

    metronome_beat_timer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_button_levels    (i_button_levels),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_beep             (o_beep),
        .o_tempo            (o_tempo),
        .o_counting_down    (o_counting_down),
        .o_silenced         (o_silenced),
        .o_settings_changed (o_settings_changed),
        .o_beat_interval    (o_beat_interval)
    );

    always #5 i_clk = ~i_clk;

    // model state and its copy of the registers
    mtb_pkg::t_action               held_action;
    logic [mtb_pkg::TEMPO_W-1:0]    tempo_now;
    logic                           down_now;
    logic                           muted_now;
    logic [mtb_pkg::INTERVAL_W-1:0] interval_now;
    logic [mtb_pkg::INTERVAL_W-1:0] ticks_now;
    logic [mtb_pkg::TEMPO_W-1:0]    bpm_upper_now;
    logic [mtb_pkg::TEMPO_W-1:0]    bpm_lower_now;
    logic [mtb_pkg::TONE_W-1:0]     tone_now;

    t_tick_result  tick_results_due[$];
    t_directed_row directed_rows[$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int ticks_sent = 0;
    int beeps_seen = 0;
    int actions_seen = 0;
    int settings_used = 1;
    int burst_left = 0;

    t_rx_mode     rx_mode = RX_STREAM;
    int           rx_left = 0;
    int           rx_period = 1;
    int           rx_phase = 0;
    t_tick_result rx_due;
    t_tick_result rx_got;

    // beat interval for a tempo, with the current tone length taken off
    function automatic logic [mtb_pkg::INTERVAL_W-1:0] interval_at(
        input logic [mtb_pkg::TEMPO_W-1:0] bpm);
        int quot;
        quot = (bpm == 0) ? 65535 : int'(mtb_pkg::MINUTE_TICKS) / int'(bpm);
        return (quot > int'(tone_now)) ? mtb_pkg::INTERVAL_W'(quot - int'(tone_now)) : '0;
    endfunction

    function automatic void restart_tempo();
        tempo_now    = mtb_pkg::TEMPO_RESET;
        down_now     = 1'b0;
        muted_now    = 1'b1;
        interval_now = (mtb_pkg::SECOND_TICKS > mtb_pkg::INTERVAL_W'(tone_now)) ?
                       mtb_pkg::SECOND_TICKS - mtb_pkg::INTERVAL_W'(tone_now) : '0;
    endfunction

    // upper bound checked first; with crossed bounds, a result below both goes to the lower bound
    function automatic void step_tempo(input logic [mtb_pkg::TEMPO_W-1:0] amount);
        int t;
        t = down_now ? int'(tempo_now) - int'(amount) : int'(tempo_now) + int'(amount);
        if (t > int'(bpm_upper_now))
            t = int'(bpm_upper_now);
        else if (t < int'(bpm_lower_now))
            t = int'(bpm_lower_now);
        tempo_now    = mtb_pkg::TEMPO_W'(t);
        interval_now = interval_at(tempo_now);
    endfunction

    // one millisecond tick: scan buttons, act on a release, then count
    function automatic t_tick_result metronome_tick(
        input logic [mtb_pkg::BUTTON_W-1:0] levels);
        t_tick_result     r;
        mtb_pkg::t_action btn;
        int               i;
        r = '0;
        for (i = 0; i < mtb_pkg::BUTTON_W; i++) begin
            btn = mtb_pkg::t_action'(mtb_pkg::HELD_W'(i + 1));
            if (levels[i]) begin
                held_action = btn;
            end else if (held_action == btn) begin
                held_action = mtb_pkg::ACT_NONE;
                r.settings_changed = 1'b1;
                case (btn)
                    mtb_pkg::ACT_RESTART:   restart_tempo();
                    mtb_pkg::ACT_DIRECTION: down_now = ~down_now;
                    mtb_pkg::ACT_STEP_ONE:  step_tempo(mtb_pkg::STEP_SMALL);
                    mtb_pkg::ACT_STEP_TEN:  step_tempo(mtb_pkg::STEP_LARGE);
                    mtb_pkg::ACT_MUTE:      muted_now = ~muted_now;
                    default: ;
                endcase
            end
        end
        if (!muted_now) begin
            ticks_now = ticks_now + 1'b1;
            if (ticks_now >= interval_now) begin
                r.beep    = 1'b1;
                ticks_now = '0;
            end
        end
        r.tempo         = tempo_now;
        r.counting_down = down_now;
        r.silenced      = muted_now;
        r.beat_interval = interval_now;
        return r;
    endfunction

    function automatic void tick_row(input logic [mtb_pkg::BUTTON_W-1:0] levels);
        t_directed_row row;
        row = '{default: '0};
        row.levels = levels;
        directed_rows.push_back(row);
    endfunction

    function automatic void typed_row(input logic [mtb_pkg::BUTTON_W-1:0] levels,
                                      input int beep, input int tempo, input int down,
                                      input int silenced, input int changed,
                                      input int interval);
        t_directed_row row;
        row = '{default: '0};
        row.levels    = levels;
        row.has_typed = 1'b1;
        row.typed     = '{1'(beep), mtb_pkg::TEMPO_W'(tempo), 1'(down), 1'(silenced),
                          1'(changed), mtb_pkg::INTERVAL_W'(interval)};
        directed_rows.push_back(row);
    endfunction

    function automatic void write_row(input logic [mtb_pkg::CFG_IDX_W-1:0] idx,
                                      input int data);
        t_directed_row row;
        row = '{default: '0};
        row.is_write  = 1'b1;
        row.reg_index = idx;
        row.reg_data  = mtb_pkg::CFG_DATA_W'(data);
        directed_rows.push_back(row);
    endfunction

    function automatic void report(input string field, input int due, input int got);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, due, got);
        mismatch_count++;
    endfunction

    // present one item, with random bursts and gaps, and predict it on acceptance
    task automatic send_tick(input logic [mtb_pkg::BUTTON_W-1:0] levels,
                             input bit has_typed, input t_tick_result typed);
        t_tick_result due;
        int           gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid         <= 1'b1;
        i_button_levels <= levels;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        due = metronome_tick(levels);
        tick_results_due.push_back(has_typed ? typed : due);
        ticks_sent++;
    endtask

    // hold the sender until every result is back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (tick_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [mtb_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [mtb_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            mtb_pkg::REG_BPM_UPPER:   bpm_upper_now = data;
            mtb_pkg::REG_BPM_LOWER:   bpm_lower_now = data;
            mtb_pkg::REG_TONE_LENGTH: tone_now      = data[mtb_pkg::TONE_W-1:0];
            default: ;
        endcase
    endtask

    // mostly clean press and release sequences, with idle runs and noise
    task automatic play_phase(input int count);
        int sent;
        int pick;
        int b;
        int n;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_tick(mtb_pkg::BUTTON_W'($urandom_range(0, 31)), 1'b0, '0);
                sent++;
            end else if (pick < 22) begin
                n = $urandom_range(5, 60);
                repeat (n) send_tick('0, 1'b0, '0);
                sent += n;
            end else begin
                pick = $urandom_range(0, 99);
                b = (pick < 8)  ? 0 :
                    (pick < 22) ? 1 :
                    (pick < 47) ? 2 :
                    (pick < 80) ? 3 : 4;
                n = $urandom_range(1, 3);
                repeat (n) send_tick(mtb_pkg::BUTTON_W'(1 << b), 1'b0, '0);
                sent += n;
                n = $urandom_range(1, 4);
                repeat (n) send_tick('0, 1'b0, '0);
                sent += n;
            end
        end
    endtask

    // pick the register setting of one random phase
    task automatic set_phase(input int p);
        int upper;
        int lower;
        int tone;
        case (p)
            0: begin upper = 511; lower = 1; tone = 255; end
            1: begin
                upper = int'(mtb_pkg::BPM_UPPER_RESET);
                lower = int'(mtb_pkg::BPM_LOWER_RESET);
                tone  = int'(mtb_pkg::TONE_LENGTH_RESET);
            end
            2: begin upper = 1; lower = 1; tone = 0; end
            3: begin
                upper = $urandom_range(1, 250);
                lower = $urandom_range(upper + 1, 511);
                tone  = $urandom_range(0, 255);
            end
            default: begin
                upper = $urandom_range(0, 511);
                lower = $urandom_range(0, upper);
                tone  = $urandom_range(100, 255);
            end
        endcase
        drain_results();
        write_register(mtb_pkg::REG_BPM_UPPER, mtb_pkg::CFG_DATA_W'(upper));
        write_register(mtb_pkg::REG_BPM_LOWER, mtb_pkg::CFG_DATA_W'(lower));
        write_register(mtb_pkg::REG_TONE_LENGTH, mtb_pkg::CFG_DATA_W'(tone));
        settings_used++;
    endtask

    // result checking, receiver stall pattern and run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && o_valid && i_ready) begin
            rx_got = '{o_beep, o_tempo, o_counting_down, o_silenced, o_settings_changed,
                       o_beat_interval};
            if (tick_results_due.size() == 0) begin
                $display("%0t ns: result item with none expected, actual %h", $time, rx_got);
                mismatch_count++;
            end else begin
                rx_due = tick_results_due.pop_front();
                if (rx_got.beep !== rx_due.beep)
                    report("beep", rx_due.beep, rx_got.beep);
                if (rx_got.tempo !== rx_due.tempo)
                    report("tempo", rx_due.tempo, rx_got.tempo);
                if (rx_got.counting_down !== rx_due.counting_down)
                    report("counting_down", rx_due.counting_down, rx_got.counting_down);
                if (rx_got.silenced !== rx_due.silenced)
                    report("silenced", rx_due.silenced, rx_got.silenced);
                if (rx_got.settings_changed !== rx_due.settings_changed)
                    report("settings_changed", rx_due.settings_changed,
                           rx_got.settings_changed);
                if (rx_got.beat_interval !== rx_due.beat_interval)
                    report("beat_interval", rx_due.beat_interval, rx_got.beat_interval);
            end
            if (o_beep === 1'b1)
                beeps_seen++;
            if (o_settings_changed === 1'b1)
                actions_seen++;
        end
        if (rx_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 2));
            rx_left   = $urandom_range(20, 200);
            rx_period = $urandom_range(2, 5);
        end
        rx_left--;
        rx_phase = (rx_phase + 1) % rx_period;
        case (rx_mode)
            RX_STREAM:   i_ready <= 1'b1;
            RX_PERIODIC: i_ready <= (rx_phase == 0);
            default:     i_ready <= ($urandom_range(0, 9) < 7);
        endcase
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: run limit reached with %0d results outstanding", $time,
                     tick_results_due.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        bpm_upper_now = mtb_pkg::BPM_UPPER_RESET;
        bpm_lower_now = mtb_pkg::BPM_LOWER_RESET;
        tone_now      = mtb_pkg::TONE_LENGTH_RESET;
        held_action   = mtb_pkg::ACT_NONE;
        ticks_now     = '0;
        restart_tempo();

        // after reset, all buttons held, unmute by release
        typed_row(5'b00000, 0, 60, 0, 1, 0, 975);
        typed_row(5'b11111, 0, 60, 0, 1, 0, 975);
        typed_row(5'b00000, 0, 60, 0, 0, 1, 975);
        // register writes leave the interval alone; unused index ignored
        write_row(mtb_pkg::REG_TONE_LENGTH, 255);
        write_row(REG_UNUSED, 511);
        write_row(mtb_pkg::REG_BPM_UPPER, 511);
        write_row(mtb_pkg::REG_BPM_LOWER, 511);
        typed_row(5'b00100, 0, 60, 0, 0, 0, 975);
        // step lands on the top tempo, zero interval beeps every tick
        typed_row(5'b00000, 1, 511, 0, 0, 1, 0);
        typed_row(5'b00000, 1, 511, 0, 0, 0, 0);
        // zero bounds give a zero tempo and a saturated quotient
        write_row(mtb_pkg::REG_BPM_UPPER, 0);
        write_row(mtb_pkg::REG_BPM_LOWER, 0);
        typed_row(5'b01000, 1, 511, 0, 0, 0, 0);
        typed_row(5'b00000, 0, 0, 0, 0, 1, 65280);
        // crossed bounds, both directions
        write_row(mtb_pkg::REG_BPM_UPPER, 100);
        write_row(mtb_pkg::REG_BPM_LOWER, 200);
        write_row(mtb_pkg::REG_TONE_LENGTH, 0);
        tick_row(5'b01000);
        tick_row(5'b00000);
        tick_row(5'b00010);
        tick_row(5'b00000);
        tick_row(5'b00100);
        tick_row(5'b00000);
        // held button moves to the highest pressed one; release of a lower one
        tick_row(5'b10001);
        tick_row(5'b00001);
        typed_row(5'b00000, 0, 60, 0, 1, 1, 1000);
        tick_row(5'b00001);
        tick_row(5'b00100);
        tick_row(5'b00000);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_write) begin
                drain_results();
                write_register(directed_rows[k].reg_index, directed_rows[k].reg_data);
            end else begin
                send_tick(directed_rows[k].levels, directed_rows[k].has_typed,
                          directed_rows[k].typed);
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_phase(p);
            play_phase(PHASE_TICKS);
        end

        drain_results();
        repeat (25) @(posedge i_clk);

        $display("ran %0d ticks across %0d register settings", ticks_sent, settings_used);
        $display("saw %0d beeps and %0d button actions", beeps_seen, actions_seen);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule
